@@ rtl/i2cbs_pkg.sv @@
package i2cbs_pkg;

  localparam int unsigned BitsPerByte = 8;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_SEND  = 3'd2;
  localparam logic [2:0] OP_RECV  = 3'd3;
  localparam logic [2:0] OP_SACK  = 3'd4;
  localparam logic [2:0] OP_RACK  = 3'd5;

  typedef logic [$clog2(BitsPerByte)-1:0] bit_idx_t;

  typedef enum logic [1:0] {
    K_START,
    K_STOP,
    K_SEND,
    K_RECV
  } kind_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] line_bits;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       last;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic       multi;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ rtl/i2c_master_bit_sequencer_unit.sv @@
// I2C master bit sequencer. Each command beat (start, stop, send byte,
// receive byte, send ack, receive ack) turns into a run of result beats, one
// per pin write, showing SCL and the SDA drive (1 = released); the last beat
// of a command carries last = 1 and, for receives, the byte or ack bit read
// from line_bits. The back sequencer makes one pin write per cycle unless the
// result register is full and not popped; writes per command: send byte 24,
// receive byte 17, start 4, stop 3, ack commands 3. Commands 6 and 7 are
// dropped and give no result. A QueueDepth-entry command queue lets commands
// be pushed while the sequencer runs; results wait in one output register.
module i2c_master_bit_sequencer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  i2cbs_pkg::in_t  in_i,
  output logic            empty,
  input  logic            pop,
  output i2cbs_pkg::out_t out_o
);

  i2cbs_pkg::cmd_t push_cmd, head_cmd;
  logic            q_push, q_full, q_valid, q_pop;

  i2cbs_front u_front (
    .item_i   (in_i),
    .push_i   (push),
    .q_full_i (q_full),
    .full_o   (full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  i2cbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  i2cbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

endmodule

@@ rtl/i2cbs_front.sv @@
module i2cbs_front (
  input  i2cbs_pkg::in_t  item_i,
  input  logic            push_i,
  input  logic            q_full_i,
  output logic            full_o,
  output logic            q_push_o,
  output i2cbs_pkg::cmd_t q_cmd_o
);

  logic known;

  always_comb begin
    known   = 1'b1;
    q_cmd_o = '{kind: i2cbs_pkg::K_START, multi: 1'b0, data: 8'h00};
    case (item_i.op)
      i2cbs_pkg::OP_START: begin
        q_cmd_o.kind = i2cbs_pkg::K_START;
      end
      i2cbs_pkg::OP_STOP: begin
        q_cmd_o.kind = i2cbs_pkg::K_STOP;
      end
      i2cbs_pkg::OP_SEND: begin
        q_cmd_o = '{kind: i2cbs_pkg::K_SEND, multi: 1'b1, data: item_i.tx_byte};
      end
      i2cbs_pkg::OP_RECV: begin
        q_cmd_o = '{kind: i2cbs_pkg::K_RECV, multi: 1'b1, data: item_i.line_bits};
      end
      i2cbs_pkg::OP_SACK: begin
        q_cmd_o = '{kind: i2cbs_pkg::K_SEND, multi: 1'b0, data: {item_i.ack_out, 7'd0}};
      end
      i2cbs_pkg::OP_RACK: begin
        q_cmd_o = '{kind: i2cbs_pkg::K_RECV, multi: 1'b0, data: item_i.line_bits};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // drop unknown commands at the door
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && known;

endmodule

@@ rtl/i2cbs_queue.sv @@
module i2cbs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cbs_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output i2cbs_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cbs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/i2cbs_back.sv @@
module i2cbs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  i2cbs_pkg::cmd_t q_cmd_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output i2cbs_pkg::out_t out_o
);

  localparam i2cbs_pkg::bit_idx_t LastBit = i2cbs_pkg::bit_idx_t'(i2cbs_pkg::BitsPerByte - 1);

  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2,
    PH_3
  } phase_e;

  i2cbs_pkg::cmd_t  cmd_q, cmd_d, cmd;
  i2cbs_pkg::out_t  out_q, out_d;
  i2cbs_pkg::bit_idx_t bit_q, bit_d;
  phase_e     phase_q, phase_d;
  logic       busy_q, busy_d;
  logic       scl_q, sda_q, scl_d, sda_d;
  logic       valid_q, valid_d;
  logic       fire, fin;

  always_comb begin
    cmd     = busy_q ? cmd_q : q_cmd_i;
    fire    = (busy_q || q_valid_i) && (!valid_q || pop_i);
    q_pop_o = fire && !busy_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    fin     = 1'b0;
    phase_d = phase_e'(phase_q + 2'd1);
    bit_d   = bit_q;
    cmd_d   = cmd;
    case (cmd.kind)
      i2cbs_pkg::K_START: begin
        case (phase_q)
          PH_0: sda_d = 1'b1;
          PH_1: scl_d = 1'b1;
          PH_2: sda_d = 1'b0;
          default: begin
            scl_d = 1'b0;
            fin   = 1'b1;
          end
        endcase
      end
      i2cbs_pkg::K_STOP: begin
        case (phase_q)
          PH_0: sda_d = 1'b0;
          PH_1: scl_d = 1'b1;
          default: begin
            sda_d = 1'b1;
            fin   = 1'b1;
          end
        endcase
      end
      default: begin
        case (phase_q)
          PH_0: sda_d = (cmd.kind == i2cbs_pkg::K_SEND) ? cmd.data[7] : 1'b1;
          PH_1: scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            fin   = (bit_q == (cmd.multi ? LastBit : '0));
            bit_d = bit_q + 1'b1;
            if (cmd.kind == i2cbs_pkg::K_SEND) begin
              phase_d    = PH_0;
              cmd_d.data = {cmd.data[6:0], 1'b0};
            end else begin
              phase_d = PH_1;
            end
          end
        endcase
      end
    endcase
    if (fin) begin
      phase_d = PH_0;
      bit_d   = '0;
    end
    busy_d = !fin;

    out_d = '{scl_level: scl_d, sda_drive: sda_d, rx_byte: 8'h00, ack_in: 1'b0, last: fin};
    if (fin && cmd.kind == i2cbs_pkg::K_RECV) begin
      if (cmd.multi) begin
        out_d.rx_byte = cmd.data;
      end else begin
        out_d.ack_in = cmd.data[7];
      end
    end

    valid_d = fire ? 1'b1 : (pop_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_0;
      bit_q   <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      valid_q <= 1'b0;
      cmd_q   <= '0;
      out_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (fire) begin
        busy_q  <= busy_d;
        phase_q <= phase_d;
        bit_q   <= bit_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        cmd_q   <= cmd_d;
        out_q   <= out_d;
      end
    end
  end

  assign empty_o = !valid_q;
  assign out_o   = out_q;

endmodule

@@ rtl/i2cbs_checker.sv @@
module i2cbs_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input i2cbs_pkg::out_t out_o
);

  logic prev_scl_q, prev_sda_q;
  logic take;

  assign take = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_scl_q <= 1'b1;
      prev_sda_q <= 1'b1;
    end else if (take) begin
      prev_scl_q <= out_o.scl_level;
      prev_sda_q <= out_o.sda_drive;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed");

  a_one_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !(out_o.scl_level != prev_scl_q && out_o.sda_drive != prev_sda_q))
    else $error("two pins moved in one write");

  a_read_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.last) |-> (out_o.rx_byte == 8'h00 && out_o.ack_in == 1'b0))
    else $error("read value on a non-final beat");

  a_ack_xor_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.ack_in) |-> (out_o.rx_byte == 8'h00 && out_o.scl_level == 1'b0))
    else $error("ack beat malformed");

endmodule

bind i2c_master_bit_sequencer_unit i2cbs_checker u_i2cbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    i2cbs_pkg::in_t  cmd;
    bit              typed;
    i2cbs_pkg::out_t fin;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  i2cbs_pkg::in_t  in_i = '0;
  logic empty;
  logic pop = 1'b0;
  i2cbs_pkg::out_t out_o;

  logic fin_use = 1'b0;
  i2cbs_pkg::out_t fin_beat = '0;

  i2cbs_pkg::out_t pin_writes_q[$];
  row_t rows[$];
  logic scl_pin = 1'b1;
  logic sda_pin = 1'b1;
  int   errs = 0;
  int   items = 0;
  int   burst_left = 0;
  int   cycles = 0;
  logic [15:0] pop_pat = '1;
  int   pop_phase = 0;
  int   pat_left = 0;

  i2c_master_bit_sequencer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void pin_write(input logic scl, input logic sda);
    i2cbs_pkg::out_t b;
    scl_pin = scl;
    sda_pin = sda;
    b = '0;
    b.scl_level = scl;
    b.sda_drive = sda;
    pin_writes_q.push_back(b);
  endfunction

  function automatic void predict_writes(input i2cbs_pkg::in_t c, input logic use_fin,
                                         input i2cbs_pkg::out_t fin);
    i2cbs_pkg::out_t tail;
    logic [7:0] rx;
    logic ack;
    rx = '0;
    ack = 1'b0;
    case (c.op)
      i2cbs_pkg::OP_START: begin
        pin_write(scl_pin, 1'b1);
        pin_write(1'b1, sda_pin);
        pin_write(scl_pin, 1'b0);
        pin_write(1'b0, sda_pin);
      end
      i2cbs_pkg::OP_STOP: begin
        pin_write(scl_pin, 1'b0);
        pin_write(1'b1, sda_pin);
        pin_write(scl_pin, 1'b1);
      end
      i2cbs_pkg::OP_SEND: begin
        for (int i = i2cbs_pkg::BitsPerByte - 1; i >= 0; i--) begin
          pin_write(scl_pin, c.tx_byte[i]);
          pin_write(1'b1, sda_pin);
          pin_write(1'b0, sda_pin);
        end
      end
      i2cbs_pkg::OP_RECV: begin
        pin_write(scl_pin, 1'b1);
        for (int i = 0; i < i2cbs_pkg::BitsPerByte; i++) begin
          pin_write(1'b1, sda_pin);
          pin_write(1'b0, sda_pin);
        end
        rx = c.line_bits;
      end
      i2cbs_pkg::OP_SACK: begin
        pin_write(scl_pin, c.ack_out);
        pin_write(1'b1, sda_pin);
        pin_write(1'b0, sda_pin);
      end
      i2cbs_pkg::OP_RACK: begin
        pin_write(scl_pin, 1'b1);
        pin_write(1'b1, sda_pin);
        pin_write(1'b0, sda_pin);
        ack = c.line_bits[7];
      end
      default: return;
    endcase
    tail = pin_writes_q[$];
    tail.rx_byte = rx;
    tail.ack_in = ack;
    tail.last = 1'b1;
    if (use_fin) tail = fin;
    pin_writes_q[$] = tail;
  endfunction

  always @(posedge clk_i) begin : monitor
    i2cbs_pkg::out_t want;
    if (rst_ni) begin
      if (push && !full) predict_writes(in_i, fin_use, fin_beat);
      if (pop && !empty) begin
        if (pin_writes_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected beat: scl=%0d sda=%0d rx=%02h ack=%0d last=%0d",
                     out_o.scl_level, out_o.sda_drive, out_o.rx_byte, out_o.ack_in,
                     out_o.last);
        end else begin
          want = pin_writes_q.pop_front();
          if (out_o !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: want scl=%0d sda=%0d rx=%02h ack=%0d last=%0d",
                       want.scl_level, want.sda_drive, want.rx_byte, want.ack_in,
                       want.last);
              $display("          got  scl=%0d sda=%0d rx=%02h ack=%0d last=%0d",
                       out_o.scl_level, out_o.sda_drive, out_o.rx_byte,
                       out_o.ack_in, out_o.last);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (pat_left == 0) begin
      if ($urandom_range(0, 3) == 0) pop_pat = '1;
      else pop_pat = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
      pat_left = $urandom_range(20, 200);
    end
    pat_left--;
    pop_phase = (pop_phase + 1) % 16;
    pop <= pop_pat[pop_phase];
  end

  function automatic i2cbs_pkg::out_t beat(input logic scl, input logic sda,
                                           input logic [7:0] rx, input logic ack);
    i2cbs_pkg::out_t b;
    b.scl_level = scl;
    b.sda_drive = sda;
    b.rx_byte = rx;
    b.ack_in = ack;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic i2cbs_pkg::in_t rand_cmd(input logic [2:0] op);
    i2cbs_pkg::in_t c;
    c.op = op;
    c.tx_byte = 8'($urandom);
    c.ack_out = 1'($urandom);
    c.line_bits = 8'($urandom);
    return c;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                                  input logic [7:0] line, input bit typed,
                                  input i2cbs_pkg::out_t fin);
    row_t r;
    r.cmd.op = op;
    r.cmd.tx_byte = tx;
    r.cmd.ack_out = ack;
    r.cmd.line_bits = line;
    r.typed = typed;
    r.fin = fin;
    rows.push_back(r);
  endfunction

  task automatic send_cmd(input i2cbs_pkg::in_t c, input bit use_fin,
                          input i2cbs_pkg::out_t fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_i <= c;
    fin_use <= use_fin;
    fin_beat <= fin;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    if (c.op <= i2cbs_pkg::OP_RACK) items++;
  endtask

  task automatic drain_bus;
    push <= 1'b0;
    while (pin_writes_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_transfers;
    int nbytes;
    bit rd;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          send_cmd(rand_cmd(i2cbs_pkg::OP_START), 0, '0);
          send_cmd(rand_cmd(i2cbs_pkg::OP_SEND), 0, '0);
          send_cmd(rand_cmd(i2cbs_pkg::OP_RACK), 0, '0);
          nbytes = $urandom_range(0, 3);
          rd = 1'($urandom);
          repeat (nbytes) begin
            if (rd) begin
              send_cmd(rand_cmd(i2cbs_pkg::OP_RECV), 0, '0);
              send_cmd(rand_cmd(i2cbs_pkg::OP_SACK), 0, '0);
            end else begin
              send_cmd(rand_cmd(i2cbs_pkg::OP_SEND), 0, '0);
              send_cmd(rand_cmd(i2cbs_pkg::OP_RACK), 0, '0);
            end
          end
          if ($urandom_range(0, 3) != 0) send_cmd(rand_cmd(i2cbs_pkg::OP_STOP), 0, '0);
        end
        7, 8: send_cmd(rand_cmd(3'($urandom_range(0, 5))), 0, '0);
        default: send_cmd(rand_cmd(3'($urandom_range(6, 7))), 0, '0);
      endcase
      if ($urandom_range(0, 19) == 0) drain_bus();
    end
  endtask

  initial begin
    add_row(i2cbs_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1, beat(1'b0, 1'b0, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_SEND, 8'h00, 1'b1, 8'hFF, 1, beat(1'b0, 1'b0, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_SEND, 8'hFF, 1'b0, 8'h00, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_SEND, 8'hA5, 1'b1, 8'h5A, 0, '0);
    add_row(i2cbs_pkg::OP_RACK, 8'hFF, 1'b1, 8'h00, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_RACK, 8'h00, 1'b0, 8'h80, 1, beat(1'b0, 1'b1, 8'h00, 1'b1));
    add_row(i2cbs_pkg::OP_RACK, 8'h00, 1'b1, 8'h7F, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_RECV, 8'hFF, 1'b1, 8'h00, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_RECV, 8'h00, 1'b0, 8'hFF, 1, beat(1'b0, 1'b1, 8'hFF, 1'b0));
    add_row(i2cbs_pkg::OP_RECV, 8'h3C, 1'b0, 8'h5A, 0, '0);
    add_row(i2cbs_pkg::OP_SACK, 8'hFF, 1'b0, 8'hFF, 1, beat(1'b0, 1'b0, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_SACK, 8'h00, 1'b1, 8'h00, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(OP_RSVD6, 8'hFF, 1'b1, 8'hFF, 0, '0);
    add_row(OP_RSVD7, 8'h00, 1'b0, 8'h00, 0, '0);
    add_row(i2cbs_pkg::OP_STOP, 8'hFF, 1'b1, 8'hFF, 1, beat(1'b1, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1, beat(1'b1, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_START, 8'hFF, 1'b1, 8'hFF, 0, '0);
    add_row(i2cbs_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0, '0);
    add_row(i2cbs_pkg::OP_SEND, 8'h80, 1'b1, 8'hFF, 0, '0);
    add_row(OP_RSVD7, 8'h55, 1'b1, 8'hAA, 0, '0);
    add_row(i2cbs_pkg::OP_SEND, 8'h01, 1'b0, 8'h00, 1, beat(1'b0, 1'b1, 8'h00, 1'b0));
    add_row(i2cbs_pkg::OP_STOP, 8'h00, 1'b1, 8'h80, 0, '0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[k]) send_cmd(rows[k].cmd, rows[k].typed, rows[k].fin);
    drain_bus();
    items = 0;
    random_transfers();
    push <= 1'b0;

    while (pin_writes_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    errs += pin_writes_q.size();
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
